>>> design/sphere_collision_impulse_top_macros.svh
// Assertion macros shared by the sphere collision impulse block.
`ifndef SPHERE_COLLISION_IMPULSE_TOP_MACROS_SVH
`define SPHERE_COLLISION_IMPULSE_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SCI_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sphere collision impulse: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define SCI_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sphere collision impulse: next-cycle check failed");

`endif

>>> design/sci_pkg.sv
// Shared constants, types and command/status structs of the sphere collision block.
package sci_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int RATIO_BITS = 20;
  localparam int REST_BITS  = 16;

  localparam int COORD_W = 32;
  localparam int MASS_W  = 31;
  localparam int REST_W  = 17;
  localparam logic [REST_W-1:0] REST_RESET = 17'd58982;

  // Internal value widths.
  localparam int ACC_W = 40;
  localparam int N_W   = FRAC_BITS + 2;
  localparam int VN_W  = 56;
  localparam int A_W   = 38;
  localparam int Q_W   = RATIO_BITS + 1;
  localparam int W_W   = 38;
  localparam int OV_W  = 36;

  // Shared multiplier: magnitudes, one 8-bit digit of b per cycle.
  localparam int MUL_W     = 40;
  localparam int MUL_DIG   = 8;
  localparam int MUL_STEPS = MUL_W / MUL_DIG;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int SPROD_W   = PROD_W + 1;

  // Radix-2 divider and bit-pair square root.
  localparam int DIV_NW = 52;
  localparam int DIV_DW = 35;
  localparam int SQ_W   = 68;
  localparam int ROOT_W = SQ_W / 2;

  typedef enum logic [4:0] {
    S_SQ0, S_SQ1, S_SQ2, S_SQRT,
    S_N0, S_N1, S_N2,
    S_VN0, S_VN1, S_VN2,
    S_A, S_Q1, S_Q2, S_W1, S_W2,
    S_DV1_0, S_DV1_1, S_DV1_2,
    S_DV2_0, S_DV2_1, S_DV2_2,
    S_S0, S_S1, S_S2
  } step_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ISSUE, ST_WAIT, ST_NEXT, ST_OUT0, ST_OUT1
  } state_t;

  typedef struct packed {
    logic  start;
    step_t step;
    logic  load_first;
    logic  load_second;
    logic  ball_sel;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic vn_pos;
  } status_t;

endpackage

>>> design/sci_mul.sv
// Sequential signed multiplier on magnitudes, one 8-bit digit per cycle.
module sci_mul
  import sci_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [MUL_W-1:0]          a,
  input  logic [MUL_W-1:0]          b,
  input  logic                      neg,
  output logic                      done,
  output logic signed [SPROD_W-1:0] prod
);

  localparam int CNT_W = $clog2(MUL_STEPS + 1);

  logic [PROD_W-1:0] a_sh;
  logic [MUL_W-1:0]  b_sh;
  logic [PROD_W-1:0] acc;
  logic [PROD_W-1:0] part;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic              neg_r;

  // Partial product of the shifted multiplicand and the low digit.
  assign part = a_sh * PROD_W'(b_sh[MUL_DIG-1:0]);

  // Iteration and accumulation.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a_sh  <= PROD_W'(a);
        b_sh  <= b;
        acc   <= '0;
        cnt   <= '0;
        neg_r <= neg;
        busy  <= 1'b1;
      end else if (busy) begin
        acc  <= acc + part;
        a_sh <= a_sh << MUL_DIG;
        b_sh <= b_sh >> MUL_DIG;
        cnt  <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(MUL_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Apply the sign to the magnitude product.
  assign prod = neg_r ? -$signed({1'b0, acc}) : $signed({1'b0, acc});

endmodule

>>> design/sci_div.sv
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
module sci_div
  import sci_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIV_NW-1:0] num,
  input  logic [DIV_DW-1:0] den,
  output logic              done,
  output logic [DIV_NW-1:0] quot
);

  localparam int CNT_W = $clog2(DIV_NW + 1);

  logic [DIV_NW-1:0] q_sh;
  logic [DIV_DW-1:0] rem;
  logic [DIV_DW-1:0] den_r;
  logic [DIV_DW:0]   trial;
  logic              fits;
  logic [CNT_W-1:0]  cnt;
  logic              busy;

  // Shift in the next dividend bit and test the divisor.
  assign trial = {rem, q_sh[DIV_NW-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        q_sh  <= num;
        rem   <= '0;
        den_r <= den;
        cnt   <= '0;
        busy  <= 1'b1;
      end else if (busy) begin
        rem  <= fits ? DIV_DW'(trial - {1'b0, den_r}) : DIV_DW'(trial);
        q_sh <= {q_sh[DIV_NW-2:0], fits};
        cnt  <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(DIV_NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = q_sh;

endmodule

>>> design/sci_sqrt.sv
// Digit-by-digit integer square root, one result bit per cycle.
module sci_sqrt
  import sci_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SQ_W-1:0]   rad,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic [SQ_W-1:0]   r_sh;
  logic [ROOT_W:0]   rem;
  logic [ROOT_W+2:0] trial;
  logic [ROOT_W+2:0] test;
  logic              fits;
  logic [CNT_W-1:0]  cnt;
  logic              busy;

  // Bring down the next bit pair and try the next root bit.
  assign trial = {rem, r_sh[SQ_W-1:SQ_W-2]};
  assign test  = {1'b0, root, 2'b01};
  assign fits  = trial >= test;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        r_sh <= rad;
        rem  <= '0;
        root <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem  <= fits ? (ROOT_W+1)'(trial - test) : (ROOT_W+1)'(trial);
        root <= {root[ROOT_W-2:0], fits};
        r_sh <= r_sh << 2;
        cnt  <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(ROOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> design/sci_datapath.sv
// Datapath: ball registers, operand selection, shared arithmetic units and write-back.
module sci_datapath
  import sci_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  cmd_t                      cmd,
  output status_t                   status,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [REST_W-1:0]         cfg_data,
  input  logic signed [COORD_W-1:0] pos_x,
  input  logic signed [COORD_W-1:0] pos_y,
  input  logic signed [COORD_W-1:0] pos_z,
  input  logic signed [COORD_W-1:0] vel_x,
  input  logic signed [COORD_W-1:0] vel_y,
  input  logic signed [COORD_W-1:0] vel_z,
  input  logic [MASS_W-1:0]         mass,
  input  logic [MASS_W-1:0]         radius,
  output logic signed [COORD_W-1:0] new_pos_x,
  output logic signed [COORD_W-1:0] new_pos_y,
  output logic signed [COORD_W-1:0] new_pos_z,
  output logic signed [COORD_W-1:0] new_vel_x,
  output logic signed [COORD_W-1:0] new_vel_y,
  output logic signed [COORD_W-1:0] new_vel_z,
  output logic                      resolved
);

  logic [REST_W-1:0]       restitution;
  logic signed [ACC_W-1:0] p1 [3];
  logic signed [ACC_W-1:0] v1 [3];
  logic signed [ACC_W-1:0] p2 [3];
  logic signed [ACC_W-1:0] v2 [3];
  logic [MASS_W-1:0]       m1, m2, r1, r2;
  logic [SQ_W-1:0]         rad;
  logic [ROOT_W-1:0]       distance;
  logic signed [N_W-1:0]   n [3];
  logic signed [VN_W-1:0]  vn_acc;
  logic signed [A_W-1:0]   a_r;
  logic [Q_W-1:0]          q1, q2;
  logic signed [W_W-1:0]   w1, w2;

  logic signed [ACC_W-1:0] d [3];
  logic signed [VN_W-1:0]  vn;
  logic signed [OV_W-1:0]  ov;
  logic [MASS_W:0]         msum;
  logic [1:0]              idx;
  logic signed [ACC_W-1:0] d_sel;
  logic signed [ACC_W-1:0] dv_sel;
  logic signed [N_W-1:0]   n_sel;

  logic                      mul_start, div_start, sqrt_start;
  logic                      mul_done, div_done, sqrt_done;
  logic [MUL_W-1:0]          mul_a, mul_b;
  logic                      mul_neg;
  logic signed [SPROD_W-1:0] prod;
  logic [DIV_NW-1:0]         div_num, quot;
  logic [DIV_DW-1:0]         div_den;
  logic [ROOT_W-1:0]         root;
  logic                      is_div, is_sqrt;

  // Magnitude of a signed value, sized for the multiplier.
  function automatic logic [MUL_W-1:0] mag(input logic signed [VN_W-1:0] x);
    logic signed [VN_W-1:0] y;
    y = x[VN_W-1] ? -x : x;
    return MUL_W'(y);
  endfunction

  // Saturate a wide signed value to the output width.
  function automatic logic signed [COORD_W-1:0] sat(input logic signed [ACC_W-1:0] x);
    logic [ACC_W-COORD_W:0] top;
    top = x[ACC_W-1:COORD_W-1];
    if ((&top) || !(|top)) return x[COORD_W-1:0];
    return x[ACC_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
  endfunction

  // Derived values.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d[i] = p1[i] - p2[i];
    end
  end
  assign vn   = vn_acc >>> FRAC_BITS;
  assign ov   = $signed(OV_W'(r1) + OV_W'(r2) - OV_W'(distance));
  assign msum = {1'b0, m1} + {1'b0, m2};

  // Vector lane of the current step.
  always_comb begin
    unique case (cmd.step) inside
      S_SQ1, S_N1, S_VN1, S_DV1_1, S_DV2_1, S_S1: idx = 2'd1;
      S_SQ2, S_N2, S_VN2, S_DV1_2, S_DV2_2, S_S2: idx = 2'd2;
      default:                                     idx = 2'd0;
    endcase
  end
  assign d_sel  = d[idx];
  assign dv_sel = v1[idx] - v2[idx];
  assign n_sel  = n[idx];

  // Operand selection for the shared units.
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    div_num = '0;
    div_den = '0;
    is_div  = 1'b0;
    is_sqrt = 1'b0;
    unique case (cmd.step) inside
      S_SQ0, S_SQ1, S_SQ2: begin
        mul_a = mag(VN_W'(d_sel));
        mul_b = mag(VN_W'(d_sel));
      end
      S_SQRT: is_sqrt = 1'b1;
      S_N0, S_N1, S_N2: begin
        is_div  = 1'b1;
        div_num = DIV_NW'(mag(VN_W'(d_sel))) << FRAC_BITS;
        div_den = DIV_DW'(distance);
      end
      S_VN0, S_VN1, S_VN2: begin
        mul_a   = mag(VN_W'(dv_sel));
        mul_b   = mag(VN_W'(n_sel));
        mul_neg = dv_sel[ACC_W-1] ^ n_sel[N_W-1];
      end
      S_A: begin
        mul_a = MUL_W'(1 << REST_BITS) + MUL_W'(restitution);
        mul_b = mag(vn);
      end
      S_Q1, S_Q2: begin
        is_div  = 1'b1;
        div_num = DIV_NW'(cmd.step == S_Q1 ? m1 : m2) << RATIO_BITS;
        div_den = DIV_DW'(msum);
      end
      S_W1, S_W2: begin
        mul_a = mag(VN_W'(a_r));
        mul_b = MUL_W'(cmd.step == S_W1 ? q2 : q1);
      end
      S_DV1_0, S_DV1_1, S_DV1_2: begin
        mul_a   = mag(VN_W'(w1));
        mul_b   = mag(VN_W'(n_sel));
        mul_neg = w1[W_W-1] ^ n_sel[N_W-1];
      end
      S_DV2_0, S_DV2_1, S_DV2_2: begin
        mul_a   = mag(VN_W'(w2));
        mul_b   = mag(VN_W'(n_sel));
        mul_neg = w2[W_W-1] ^ n_sel[N_W-1];
      end
      default: begin
        mul_a   = mag(VN_W'(ov));
        mul_b   = mag(VN_W'(n_sel));
        mul_neg = ov[OV_W-1] ^ n_sel[N_W-1];
      end
    endcase
  end

  assign mul_start  = cmd.start && !is_div && !is_sqrt;
  assign div_start  = cmd.start && is_div;
  assign sqrt_start = cmd.start && is_sqrt;

  sci_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .neg(mul_neg), .done(mul_done), .prod(prod)
  );

  sci_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quot(quot)
  );

  sci_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sqrt_start), .rad(rad),
    .done(sqrt_done), .root(root)
  );

  assign status.done   = mul_done || div_done || sqrt_done;
  assign status.vn_pos = vn > 0;

  // Restitution register.
  always_ff @(posedge clk) begin
    if (rst) begin
      restitution <= REST_RESET;
    end else if (cfg_valid && cfg_ready) begin
      restitution <= cfg_data;
    end
  end

  // Ball capture and step write-back.
  always_ff @(posedge clk) begin
    if (cmd.load_first) begin
      p1[0] <= ACC_W'(pos_x);
      p1[1] <= ACC_W'(pos_y);
      p1[2] <= ACC_W'(pos_z);
      v1[0] <= ACC_W'(vel_x);
      v1[1] <= ACC_W'(vel_y);
      v1[2] <= ACC_W'(vel_z);
      m1    <= mass;
      r1    <= radius;
    end else if (cmd.load_second) begin
      p2[0]  <= ACC_W'(pos_x);
      p2[1]  <= ACC_W'(pos_y);
      p2[2]  <= ACC_W'(pos_z);
      v2[0]  <= ACC_W'(vel_x);
      v2[1]  <= ACC_W'(vel_y);
      v2[2]  <= ACC_W'(vel_z);
      m2     <= mass;
      r2     <= radius;
      rad    <= '0;
      vn_acc <= '0;
    end else if (status.done) begin
      unique case (cmd.step) inside
        S_SQ0, S_SQ1, S_SQ2: rad <= rad + SQ_W'(prod);
        S_SQRT:              distance <= root;
        S_N0, S_N1, S_N2: begin
          if (distance == '0) n[idx] <= '0;
          else if (d_sel[ACC_W-1]) n[idx] <= -$signed(N_W'(quot));
          else n[idx] <= $signed(N_W'(quot));
        end
        S_VN0, S_VN1, S_VN2: vn_acc <= vn_acc + VN_W'(prod);
        S_A:  a_r <= A_W'(prod >>> REST_BITS);
        S_Q1: q1 <= (msum == '0) ? '0 : Q_W'(quot);
        S_Q2: q2 <= (msum == '0) ? '0 : Q_W'(quot);
        S_W1: w1 <= W_W'(prod >>> RATIO_BITS);
        S_W2: w2 <= W_W'(prod >>> RATIO_BITS);
        S_DV1_0, S_DV1_1, S_DV1_2: v1[idx] <= v1[idx] + ACC_W'(prod >>> FRAC_BITS);
        S_DV2_0, S_DV2_1, S_DV2_2: v2[idx] <= v2[idx] - ACC_W'(prod >>> FRAC_BITS);
        default: begin
          p1[idx] <= p1[idx] + ACC_W'(prod >>> (FRAC_BITS + 1));
          p2[idx] <= p2[idx] - ACC_W'(prod >>> (FRAC_BITS + 1));
        end
      endcase
    end
  end

  // Result item of the selected ball.
  assign new_pos_x = sat(cmd.ball_sel ? p2[0] : p1[0]);
  assign new_pos_y = sat(cmd.ball_sel ? p2[1] : p1[1]);
  assign new_pos_z = sat(cmd.ball_sel ? p2[2] : p1[2]);
  assign new_vel_x = sat(cmd.ball_sel ? v2[0] : v1[0]);
  assign new_vel_y = sat(cmd.ball_sel ? v2[1] : v1[1]);
  assign new_vel_z = sat(cmd.ball_sel ? v2[2] : v1[2]);
  assign resolved  = !status.vn_pos;

endmodule

>>> design/sci_ctrl.sv
// Controller: pairs balls, sequences the arithmetic steps and hands out two results.
module sci_ctrl
  import sci_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;
  step_t  step, step_next;
  logic   have_first, have_first_next;
  logic   accept;

  assign in_stall = state != ST_IDLE;
  assign accept   = in_valid && !in_stall;

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      step       <= S_SQ0;
      have_first <= 1'b0;
    end else begin
      state      <= state_next;
      step       <= step_next;
      have_first <= have_first_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next      = state;
    step_next       = step;
    have_first_next = have_first;
    out_valid       = 1'b0;
    cmd.start       = 1'b0;
    cmd.step        = step;
    cmd.load_first  = accept && !have_first;
    cmd.load_second = accept && have_first;
    cmd.ball_sel    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          have_first_next = !have_first;
          if (have_first) begin
            step_next  = S_SQ0;
            state_next = ST_ISSUE;
          end
        end
      end
      ST_ISSUE: begin
        cmd.start  = 1'b1;
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (status.done) state_next = ST_NEXT;
      end
      ST_NEXT: begin
        // A separating pair skips the impulse and separation steps.
        if (step == S_S2 || (step == S_VN2 && status.vn_pos)) begin
          state_next = ST_OUT0;
        end else begin
          step_next  = step_t'(step + 5'd1);
          state_next = ST_ISSUE;
        end
      end
      ST_OUT0: begin
        out_valid = 1'b1;
        if (!out_stall) state_next = ST_OUT1;
      end
      ST_OUT1: begin
        out_valid    = 1'b1;
        cmd.ball_sel = 1'b1;
        if (!out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

>>> design/sphere_collision_impulse_top.sv
// Top level of the sphere collision impulse block.
// Balls arrive one item at a time; the first of a pair is captured and
// gives no result, the second starts the solve and the pair's two results
// (first ball, then second) follow. A colliding pair runs five radix-2
// divisions (three normal components and two mass ratios) on the shared
// divider, a square root and eighteen multiplies on the shared multiplier;
// a separating pair stops early and skips the impulse and separation steps.
// No new ball is taken until both results of a pair have been delivered.
`include "sphere_collision_impulse_top_macros.svh"

module sphere_collision_impulse_top
  import sci_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [REST_W-1:0]         cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [COORD_W-1:0] pos_x,
  input  logic signed [COORD_W-1:0] pos_y,
  input  logic signed [COORD_W-1:0] pos_z,
  input  logic signed [COORD_W-1:0] vel_x,
  input  logic signed [COORD_W-1:0] vel_y,
  input  logic signed [COORD_W-1:0] vel_z,
  input  logic [MASS_W-1:0]         mass,
  input  logic [MASS_W-1:0]         radius,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      ball_index,
  output logic signed [COORD_W-1:0] new_pos_x,
  output logic signed [COORD_W-1:0] new_pos_y,
  output logic signed [COORD_W-1:0] new_pos_z,
  output logic signed [COORD_W-1:0] new_vel_x,
  output logic signed [COORD_W-1:0] new_vel_y,
  output logic signed [COORD_W-1:0] new_vel_z,
  output logic                      resolved,
  output logic                      last
);

  cmd_t    cmd;
  status_t status;

  // The restitution register takes a write at any time.
  assign cfg_ready = 1'b1;

  sci_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .status(status), .cmd(cmd)
  );

  sci_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .vel_x(vel_x), .vel_y(vel_y), .vel_z(vel_z),
    .mass(mass), .radius(radius),
    .new_pos_x(new_pos_x), .new_pos_y(new_pos_y), .new_pos_z(new_pos_z),
    .new_vel_x(new_vel_x), .new_vel_y(new_vel_y), .new_vel_z(new_vel_z),
    .resolved(resolved)
  );

  assign ball_index = cmd.ball_sel;
  assign last       = cmd.ball_sel;

  // No ball is taken while results are on offer.
  `SCI_ASSERT_IMP(a_no_in_while_out, clk, rst, out_valid, in_stall)
  // Arithmetic never starts while results are on offer.
  `SCI_ASSERT_IMP(a_no_start_while_out, clk, rst, cmd.start, !out_valid)
  // The final result of a pair ends the output phase.
  `SCI_ASSERT_NXT(a_last_ends_pair, clk, rst, out_valid && !out_stall && last, !out_valid)

endmodule
